[sv/triangle_distance_histogram_defines.svh]
// assertion macros for the triangle distance histogram
`ifndef TRIANGLE_DISTANCE_HISTOGRAM_DEFINES_SVH
`define TRIANGLE_DISTANCE_HISTOGRAM_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TDH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TDH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tdh_pkg.sv]
`timescale 1ns / 1ps
package tdh_pkg;

    localparam int COORD_W = 24;
    localparam int MAG_W   = 25;
    localparam int SQ_W    = 50;
    localparam int ROOT_W  = 25;
    localparam int IDX_W   = 12;
    localparam int CFG_W   = 24;
    localparam int OUT_CNT_W = 48;

    localparam logic CMD_ACC  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [1:0] REG_RANGE_MIN = 2'd0;
    localparam logic [1:0] REG_RANGE_MAX = 2'd1;
    localparam logic [1:0] REG_BIN_STEP  = 2'd2;

    typedef struct packed {
        logic                       cmd;
        logic [2:0][SQ_W-1:0]       sq;
        logic [IDX_W-1:0]           read_index;
    } item_t;

    typedef struct packed {
        logic [CFG_W-1:0] range_min;
        logic [CFG_W-1:0] range_max;
        logic [CFG_W-1:0] bin_step;
    } cfg_t;

    function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y);
        logic signed [MAG_W-1:0] d;
        d = $signed({x[COORD_W-1], x}) - $signed({y[COORD_W-1], y});
        return d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
    endfunction

endpackage

[sv/triangle_distance_histogram.sv]
`timescale 1ns / 1ps
// Triangle side-length histogram. Each s_ word is an accumulate (s_tuser 0) carrying three
// Q8.16 points, or a read (s_tuser 1) of one histogram entry; each produces one m_ word.
// The front end squares an accumulate's nine differences through one multiplier, takes no
// new word until the last is queued, and queues up to two words. The back end is a single
// sequencer that runs the one-bit-per-cycle square root and bin divider once per side,
// stopping at the first side out of range. After reset a clearing pass zeroes all NUM_BINS**3
// entries before the first word is processed; config writes are taken meanwhile.
module triangle_distance_histogram #(
    parameter int NUM_BINS   = 16,
    parameter int COUNT_BITS = 48
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [23:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ax, ay, az, bx, by, bz, cx, cy, cz, read_index, zero pad
    input  logic [231:0] s_tdata,
    // cmd
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // combined_bin, bin_count, zero pad
    output logic [63:0]  m_tdata,
    // in_range
    output logic         m_tuser
);

    tdh_pkg::cfg_t  cfg_reg;
    logic           q_valid;
    tdh_pkg::item_t q_data;
    logic           q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.range_min <= 24'd0;
            cfg_reg.range_max <= 24'd2724280;
            cfg_reg.bin_step  <= 24'd170268;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                tdh_pkg::REG_RANGE_MIN: cfg_reg.range_min <= cfg_wdata;
                tdh_pkg::REG_RANGE_MAX: cfg_reg.range_max <= cfg_wdata;
                tdh_pkg::REG_BIN_STEP:  cfg_reg.bin_step  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    tdh_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    tdh_back #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[sv/tdh_ram.sv]
`timescale 1ns / 1ps
module tdh_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/tdh_front.sv]
`timescale 1ns / 1ps
module tdh_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    // ax, ay, az, bx, by, bz, cx, cy, cz, read_index, zero pad
    input  logic [231:0]   s_tdata,
    // cmd
    input  logic           s_tuser,
    output logic           q_valid,
    output tdh_pkg::item_t q_data,
    input  logic           q_pop
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQ   = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [tdh_pkg::MAG_W-1:0]   mag_reg [9];
    logic [tdh_pkg::MAG_W-1:0]   mag_in [9];
    logic [2*tdh_pkg::MAG_W-1:0] sq_cur;
    logic [3:0]                  cnt_reg, cnt_next;
    logic [1:0]                  grp_reg, grp_next;
    logic [1:0]                  pos_reg, pos_next;
    logic [tdh_pkg::SQ_W-1:0]    prod_reg;
    logic [1:0]                  prod_grp_reg;
    logic                        prod_vld_reg, prod_vld_next;
    tdh_pkg::item_t              item_reg;
    logic                        accept;
    logic                        push;

    tdh_pkg::item_t              fifo_mem [2];
    logic                        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                  fill_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign push     = (state_reg == ST_PUSH) && (fill_reg != 2'd2);
    assign sq_cur   = mag_reg[cnt_reg] * mag_reg[cnt_reg];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag_in[k]   = tdh_pkg::abs_diff(s_tdata[24*k +: 24], s_tdata[24*(3+k) +: 24]);
            mag_in[3+k] = tdh_pkg::abs_diff(s_tdata[24*k +: 24], s_tdata[24*(6+k) +: 24]);
            mag_in[6+k] = tdh_pkg::abs_diff(s_tdata[24*(3+k) +: 24], s_tdata[24*(6+k) +: 24]);
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        grp_next      = grp_reg;
        pos_next      = pos_reg;
        prod_vld_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = 4'd0;
                grp_next = 2'd0;
                pos_next = 2'd0;
                if (accept) begin
                    state_next = (s_tuser == tdh_pkg::CMD_READ) ? ST_PUSH : ST_SQ;
                end
            end
            ST_SQ: begin
                if (cnt_reg < 4'd9) begin
                    prod_vld_next = 1'b1;
                    cnt_next      = cnt_reg + 4'd1;
                    if (pos_reg == 2'd2) begin
                        pos_next = 2'd0;
                        grp_next = grp_reg + 2'd1;
                    end else begin
                        pos_next = pos_reg + 2'd1;
                    end
                end else begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (push) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            prod_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            prod_vld_reg <= prod_vld_next;
        end
        cnt_reg <= cnt_next;
        grp_reg <= grp_next;
        pos_reg <= pos_next;
        if (state_reg == ST_SQ && cnt_reg < 4'd9) begin
            prod_reg     <= sq_cur;
            prod_grp_reg <= grp_reg;
        end
        if (accept) begin
            for (int k = 0; k < 9; k++) begin
                mag_reg[k] <= mag_in[k];
            end
            item_reg.cmd        <= s_tuser;
            item_reg.sq         <= '0;
            item_reg.read_index <= s_tdata[216 +: 12];
        end else if (prod_vld_reg) begin
            item_reg.sq[prod_grp_reg] <= item_reg.sq[prod_grp_reg] + prod_reg;
        end
    end

    // two-word queue towards the back end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, q_pop};
        end
        if (push) begin
            fifo_mem[wr_ptr_reg] <= item_reg;
        end
    end

    assign q_valid = (fill_reg != 2'd0);
    assign q_data  = fifo_mem[rd_ptr_reg];

endmodule

[sv/tdh_back.sv]
`timescale 1ns / 1ps
`include "triangle_distance_histogram_defines.svh"
module tdh_back #(
    parameter int NUM_BINS   = 16,
    parameter int COUNT_BITS = 48
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  tdh_pkg::cfg_t  cfg,
    input  logic           q_valid,
    input  tdh_pkg::item_t q_data,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    // combined_bin, bin_count, zero pad
    output logic [63:0]    m_tdata,
    // in_range
    output logic           m_tuser
);

    localparam int DEPTH = NUM_BINS * NUM_BINS * NUM_BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(NUM_BINS);
    localparam int NN    = NUM_BINS * NUM_BINS;
    localparam int RW    = tdh_pkg::ROOT_W;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_SQRT  = 4'd2;
    localparam logic [3:0] ST_CHK   = 4'd3;
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_CMB   = 4'd5;
    localparam logic [3:0] ST_RD    = 4'd6;
    localparam logic [3:0] ST_UPD   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [3:0]                 state_reg;
    logic [AW-1:0]              addr_reg;
    tdh_pkg::item_t             item_reg;
    logic [1:0]                 side_reg;
    logic [4:0]                 step_reg;
    logic [tdh_pkg::SQ_W-1:0]   n_reg;
    logic [RW+1:0]              rem_reg;
    logic [RW-1:0]              root_reg;
    logic [RW-1:0]              num_reg;
    logic [RW-1:0]              drem_reg;
    logic [RW-1:0]              quo_reg;
    logic [BW-1:0]              bins_reg [3];
    logic [AW-1:0]              idx_reg;
    logic                       hit_reg;
    logic [tdh_pkg::IDX_W-1:0]  res_bin_reg;
    logic                       res_in_reg;
    logic [COUNT_BITS-1:0]      res_cnt_reg;
    logic                       m_tvalid_reg;
    logic [63:0]                m_tdata_reg;
    logic                       m_tuser_reg;

    logic [RW+1:0]              rem_sh, trial;
    logic [RW-1:0]              drem_sh;
    logic [RW-1:0]              quo_next;
    logic                       div_ge;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [COUNT_BITS-1:0]      ram_wdata, ram_rdata, cnt_inc;
    logic                       out_free;

    assign rem_sh   = {rem_reg[RW-1:0], n_reg[tdh_pkg::SQ_W-1 -: 2]};
    assign trial    = {root_reg, 2'b01};
    assign drem_sh  = {drem_reg[RW-2:0], num_reg[RW-1]};
    assign div_ge   = drem_sh >= {1'b0, cfg.bin_step};
    assign quo_next = {quo_reg[RW-2:0], div_ge};
    assign cnt_inc  = (&ram_rdata) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
    assign out_free = !m_tvalid_reg || m_tready;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = cnt_inc;
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = addr_reg;
            ram_wdata = '0;
        end else if (state_reg == ST_UPD && item_reg.cmd == tdh_pkg::CMD_ACC) begin
            ram_we = 1'b1;
        end
    end

    assign ram_raddr = idx_reg;

    tdh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            addr_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    addr_reg <= addr_reg + AW'(1);
                    if (addr_reg == AW'(DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (q_valid) begin
                        item_reg <= q_data;
                        side_reg <= 2'd0;
                        step_reg <= '0;
                        n_reg    <= q_data.sq[0];
                        rem_reg  <= '0;
                        root_reg <= '0;
                        idx_reg  <= AW'(q_data.read_index);
                        hit_reg  <= 32'(q_data.read_index) < DEPTH;
                        state_reg <= (q_data.cmd == tdh_pkg::CMD_READ) ? ST_RD : ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    n_reg <= n_reg << 2;
                    if (rem_sh >= trial) begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[RW-2:0], 1'b1};
                    end else begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[RW-2:0], 1'b0};
                    end
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(RW - 1)) begin
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    step_reg <= '0;
                    drem_reg <= '0;
                    quo_reg  <= '0;
                    num_reg  <= root_reg - {1'b0, cfg.range_min};
                    if (root_reg < {1'b0, cfg.range_min} || root_reg >= {1'b0, cfg.range_max}
                        || cfg.bin_step == '0) begin
                        hit_reg   <= 1'b0;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    num_reg  <= num_reg << 1;
                    drem_reg <= div_ge ? drem_sh - {1'b0, cfg.bin_step} : drem_sh;
                    quo_reg  <= quo_next;
                    if (step_reg == 5'(RW - 1)) begin
                        bins_reg[side_reg] <= quo_next[BW-1:0];
                        step_reg <= '0;
                        rem_reg  <= '0;
                        root_reg <= '0;
                        if (quo_next >= RW'(NUM_BINS)) begin
                            hit_reg   <= 1'b0;
                            state_reg <= ST_OUT;
                        end else if (side_reg == 2'd2) begin
                            hit_reg   <= 1'b1;
                            state_reg <= ST_CMB;
                        end else begin
                            side_reg  <= side_reg + 2'd1;
                            n_reg     <= item_reg.sq[side_reg + 2'd1];
                            state_reg <= ST_SQRT;
                        end
                    end else begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                ST_CMB: begin
                    idx_reg   <= AW'(32'(bins_reg[2]) * NN + 32'(bins_reg[1]) * NUM_BINS
                                     + 32'(bins_reg[0]));
                    state_reg <= ST_RD;
                end
                ST_RD: begin
                    state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
        if (state_reg == ST_UPD) begin
            res_cnt_reg <= (item_reg.cmd == tdh_pkg::CMD_ACC) ? cnt_inc
                         : (hit_reg ? ram_rdata : '0);
        end
        if (state_reg == ST_OUT && out_free) begin
            if (item_reg.cmd == tdh_pkg::CMD_READ) begin
                m_tdata_reg <= {4'd0, tdh_pkg::OUT_CNT_W'(res_cnt_reg), item_reg.read_index};
                m_tuser_reg <= 1'b0;
            end else if (hit_reg) begin
                m_tdata_reg <= {4'd0, tdh_pkg::OUT_CNT_W'(res_cnt_reg),
                                tdh_pkg::IDX_W'(idx_reg)};
                m_tuser_reg <= 1'b1;
            end else begin
                m_tdata_reg <= '0;
                m_tuser_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `TDH_ASSERT_IMP(a_no_pop_in_clear, state_reg == ST_CLEAR, !q_pop, "pop during clear")
    `TDH_ASSERT_IMP(a_we_states, ram_we, (state_reg == ST_CLEAR) || (state_reg == ST_UPD),
                    "histogram write outside clear or update")
    `TDH_ASSERT_NXT(a_pop_starts, q_pop, (state_reg == ST_SQRT) || (state_reg == ST_RD),
                    "popped word not started")

endmodule
